/* hw/rtl/pcdm_pkg.sv */
package pcdm_pkg;

	localparam int POS_W      = 48;
	localparam int TIME_W     = 48;
	localparam int DELAY_W    = 24;
	localparam int RATE_W     = 20;
	localparam int CNT_W      = 32;
	localparam int DRIFT_W    = 32;
	localparam int TOTAL_W    = 64;
	localparam int FRAC_BITS  = 8;
	localparam int ADDR_W     = 3;
	localparam int DATA_W     = 32;

	localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(48000);
	localparam logic [0:0] REG_SAMPLE_RATE = 1'b0;

	localparam logic [63:0] NS_PER_S   = 64'd1_000_000_000;
	localparam logic [63:0] PPM_SCALE  = 64'd1_000_000;

	// Bit length of NS_PER_S * PPM_SCALE.
	localparam int SCALE_W = 50;
	// The position step magnitude never exceeds 2^(POS_W-1).
	localparam int PROD_W  = POS_W - 1 + SCALE_W;
	localparam int NUM_W   = PROD_W + FRAC_BITS;
	localparam int DEN_W   = TIME_W + RATE_W;
	localparam int ALU_W   = NUM_W + 1;
	localparam int ITER_W  = $clog2(NUM_W);

	localparam logic [PROD_W-1:0] NUM_SCALE  = PROD_W'(NS_PER_S * PPM_SCALE);
	localparam logic [63:0]       DRIFT_BIAS = PPM_SCALE << FRAC_BITS;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef struct packed {
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
		logic             inv_b;
		logic             cin;
	} pcdm_alu_req_t;

	typedef struct packed {
		logic [ALU_W-1:0] sum;
		logic             cout;
	} pcdm_alu_rsp_t;

	typedef struct packed {
		logic [POS_W-1:0]          frames_written;
		logic signed [DELAY_W-1:0] delay_frames;
		logic [TIME_W-1:0]         timestamp_ns;
	} pcdm_item_t;

	typedef struct packed {
		logic [POS_W-1:0]          position_frames;
		logic signed [DRIFT_W-1:0] cycle_drift;
		logic signed [DRIFT_W-1:0] average_drift;
		logic [CNT_W-1:0]          event_count;
		logic signed [DELAY_W-1:0] first_delay;
		logic                      drift_valid;
	} pcdm_result_t;

	// Signed saturation of a sign and magnitude pair to the drift field.
	function automatic logic signed [DRIFT_W-1:0] sat_drift(input logic neg,
			input logic [ALU_W-1:0] mag);
		logic signed [DRIFT_W-1:0] r;
		if (neg) begin
			if ((|mag[ALU_W-1:DRIFT_W]) || (mag[DRIFT_W-1] && (|mag[DRIFT_W-2:0]))) begin
				r = {1'b1, {(DRIFT_W-1){1'b0}}};
			end else begin
				r = -$signed(mag[DRIFT_W-1:0]);
			end
		end else begin
			if (|mag[ALU_W-1:DRIFT_W-1]) begin
				r = {1'b0, {(DRIFT_W-1){1'b1}}};
			end else begin
				r = $signed(mag[DRIFT_W-1:0]);
			end
		end
		return r;
	endfunction

endpackage

/* hw/rtl/playback_clock_drift_meter.sv */
// Playback clock drift meter.
// One input transaction on the s_axis channel carries one period event: frames
// written, the reported delay and a nanosecond timestamp. Each event gives
// exactly one result transaction on the m_axis channel with the consumed
// position, the drift of this interval, the running average drift, the event
// count and the delay latched with the first event; m_axis_tuser flags a
// measured interval. Drift values are in 1/256 ppm.
// The sample rate register sits at APB address 0; the user must write it only
// while idle; the block itself does not enforce this. Events are handled one
// at a time by a sequencer around a single shared adder. A measured interval
// runs multiply steps for the scaled position step and the time step times the
// rate, restoring divide steps for the drift (plus a rounding step when the
// position moved forward by fewer frames than the rate asks for) and the
// average, and set-up steps. The first event skips it all; zero time skips the
// drift. s_axis_tready is high only while the sequencer is idle, so the next
// event is taken no sooner than the cycle after the result is registered.
// The result waits in an output register; while the receiver stalls, the next
// event is already taken and computed, and it waits until that register frees.
// Reset clears all history and sets the sample rate to 48000.
module playback_clock_drift_meter
	import pcdm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	// frames_written[47:0], delay_frames[71:48], timestamp_ns[119:72]
	input  logic [119:0]      s_axis_tdata,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	// position_frames[47:0], cycle_drift[79:48], average_drift[111:80],
	// event_count[143:112], first_delay[167:144]
	output logic [167:0]      m_axis_tdata,
	// drift_valid[0]
	output logic              m_axis_tuser
);

	logic [RATE_W-1:0] sample_rate;
	pcdm_item_t        item;
	pcdm_result_t      result;
	pcdm_alu_req_t     alu_req;
	pcdm_alu_rsp_t     alu_rsp;

	assign item.frames_written = s_axis_tdata[47:0];
	assign item.delay_frames   = $signed(s_axis_tdata[71:48]);
	assign item.timestamp_ns   = s_axis_tdata[119:72];

	assign m_axis_tdata = {result.first_delay, result.event_count, result.average_drift,
		result.cycle_drift, result.position_frames};
	assign m_axis_tuser = result.drift_valid;

	pcdm_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.sample_rate (sample_rate)
	);

	pcdm_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	pcdm_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_rate (sample_rate),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_item     (item),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_result  (result),
		.alu_req     (alu_req),
		.alu_rsp     (alu_rsp)
	);

endmodule

/* hw/rtl/pcdm_alu.sv */
module pcdm_alu
	import pcdm_pkg::*;
(
	input  pcdm_alu_req_t req,
	output pcdm_alu_rsp_t rsp
);

	logic [ALU_W-1:0] b_eff;
	logic [ALU_W:0]   total;

	assign b_eff = req.inv_b ? ~req.b : req.b;
	assign total = {1'b0, req.a} + {1'b0, b_eff} + {{ALU_W{1'b0}}, req.cin};
	assign rsp.sum  = total[ALU_W-1:0];
	assign rsp.cout = total[ALU_W];

endmodule

/* hw/rtl/pcdm_cfg.sv */
module pcdm_cfg
	import pcdm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output logic [RATE_W-1:0] sample_rate
);

	logic [RATE_W-1:0] rate_q;
	logic              hit;

	assign pready      = 1'b1;
	assign hit         = (paddr[2] == REG_SAMPLE_RATE);
	assign sample_rate = rate_q;
	assign prdata      = hit ? DATA_W'(rate_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_RESET;
		end else if (psel && penable && pwrite && pready && hit) begin
			rate_q <= pwdata[RATE_W-1:0];
		end
	end

endmodule

/* hw/rtl/pcdm_core.sv */
module pcdm_core
	import pcdm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [RATE_W-1:0] sample_rate,
	input  logic              in_valid,
	output logic              in_ready,
	input  pcdm_item_t        in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output pcdm_result_t      out_result,
	output pcdm_alu_req_t     alu_req,
	input  pcdm_alu_rsp_t     alu_rsp
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_PREP = 4'd1;
	localparam logic [3:0] S_MAG  = 4'd2;
	localparam logic [3:0] S_MULN = 4'd3;
	localparam logic [3:0] S_MULD = 4'd4;
	localparam logic [3:0] S_DIVD = 4'd5;
	localparam logic [3:0] S_ADJ1 = 4'd6;
	localparam logic [3:0] S_ADJ2 = 4'd7;
	localparam logic [3:0] S_SATC = 4'd8;
	localparam logic [3:0] S_TOT  = 4'd9;
	localparam logic [3:0] S_MNEG = 4'd10;
	localparam logic [3:0] S_DIVM = 4'd11;
	localparam logic [3:0] S_MSAT = 4'd12;
	localparam logic [3:0] S_DONE = 4'd13;

	logic [3:0]                state_q;
	logic [ITER_W-1:0]         cnt_q;
	logic [CNT_W-1:0]          ev_q;
	logic                      first_seen_q;
	logic signed [DELAY_W-1:0] first_delay_q;
	logic signed [TOTAL_W-1:0] total_q;
	logic signed [DRIFT_W-1:0] mean_q;
	logic [POS_W-1:0]          prev_pos_q;
	logic [TIME_W-1:0]         prev_time_q;
	logic                      out_valid_q;
	pcdm_result_t              result_q;

	logic [POS_W-1:0]          pos_q;
	logic [TIME_W-1:0]         now_q;
	logic [POS_W-1:0]          dp_q;
	logic [TIME_W-1:0]         dt_q;
	logic                      back_q;
	logic                      neg_q;
	logic [ALU_W-1:0]          acc_q;
	logic [PROD_W-1:0]         mcand_q;
	logic [POS_W-1:0]          mplier_q;
	logic [NUM_W-1:0]          dvd_q;
	logic [DEN_W-1:0]          rem_q;
	logic [DEN_W-1:0]          den_q;
	logic signed [DRIFT_W-1:0] cyc_q;
	logic                      valid_q;

	logic                      accept;
	logic                      load_out;
	logic [POS_W-1:0]          new_pos;
	logic [DEN_W:0]            trial_in;
	logic [TOTAL_W-1:0]        cyc_ext;
	logic [TOTAL_W-1:0]        sum64;
	logic                      tot_ovf;
	logic [TOTAL_W-1:0]        tmag;

	assign in_ready   = (state_q == S_IDLE);
	assign accept     = in_valid && in_ready;
	assign load_out   = (state_q == S_DONE) && (!out_valid_q || out_ready);
	assign out_valid  = out_valid_q;
	assign out_result = result_q;

	assign new_pos  = in_item.frames_written
		- POS_W'({{(POS_W-DELAY_W){in_item.delay_frames[DELAY_W-1]}}, in_item.delay_frames});
	assign trial_in = {rem_q, dvd_q[NUM_W-1]};
	assign cyc_ext  = {{(TOTAL_W-DRIFT_W){cyc_q[DRIFT_W-1]}}, cyc_q};
	assign sum64    = alu_rsp.sum[TOTAL_W-1:0];
	assign tot_ovf  = (total_q[TOTAL_W-1] == cyc_q[DRIFT_W-1])
		&& (sum64[TOTAL_W-1] != total_q[TOTAL_W-1]);
	assign tmag     = total_q[TOTAL_W-1] ? sum64 : $unsigned(total_q);

	always_comb begin
		alu_req = '0;
		case (state_q)
			S_MULN, S_MULD: begin
				alu_req.a = acc_q;
				alu_req.b = mplier_q[0] ? ALU_W'(mcand_q) : '0;
			end
			S_DIVD, S_DIVM: begin
				alu_req.a     = ALU_W'(trial_in);
				alu_req.b     = ALU_W'(den_q);
				alu_req.inv_b = 1'b1;
				alu_req.cin   = 1'b1;
			end
			S_ADJ1: begin
				alu_req.a     = ALU_W'(dvd_q);
				alu_req.b     = ALU_W'(DRIFT_BIAS);
				alu_req.inv_b = !back_q;
				alu_req.cin   = !back_q;
			end
			S_ADJ2: begin
				// The quotient lies below the bias; a nonzero remainder rounds toward zero.
				alu_req.a     = ALU_W'(DRIFT_BIAS);
				alu_req.b     = ALU_W'(dvd_q);
				alu_req.inv_b = 1'b1;
				alu_req.cin   = (rem_q == '0);
			end
			S_TOT: begin
				alu_req.a = ALU_W'($unsigned(total_q));
				alu_req.b = ALU_W'(cyc_ext);
			end
			S_MNEG: begin
				alu_req.b     = ALU_W'($unsigned(total_q));
				alu_req.inv_b = 1'b1;
				alu_req.cin   = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cnt_q         <= '0;
			ev_q          <= '0;
			first_seen_q  <= 1'b0;
			first_delay_q <= '0;
			total_q       <= '0;
			mean_q        <= '0;
			prev_pos_q    <= '0;
			prev_time_q   <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (!first_seen_q) begin
							first_delay_q <= in_item.delay_frames;
							first_seen_q  <= 1'b1;
						end
						if (ev_q != CNT_MAX) begin
							ev_q <= ev_q + 1'b1;
						end
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					state_q <= (ev_q > CNT_W'(1)) ? S_MAG : S_DONE;
				end
				S_MAG: begin
					if (dt_q == '0 || sample_rate == '0) begin
						state_q <= S_MNEG;
					end else begin
						cnt_q   <= ITER_W'(POS_W - 1);
						state_q <= S_MULN;
					end
				end
				S_MULN: begin
					if (cnt_q == '0) begin
						cnt_q   <= ITER_W'(RATE_W - 1);
						state_q <= S_MULD;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_MULD: begin
					if (cnt_q == '0) begin
						cnt_q   <= ITER_W'(NUM_W - 1);
						state_q <= S_DIVD;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_DIVD: begin
					if (cnt_q == '0) begin
						state_q <= S_ADJ1;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_ADJ1: begin
					state_q <= (!back_q && !alu_rsp.cout) ? S_ADJ2 : S_SATC;
				end
				S_ADJ2: begin
					state_q <= S_SATC;
				end
				S_SATC: begin
					state_q <= S_TOT;
				end
				S_TOT: begin
					if (tot_ovf) begin
						total_q <= total_q[TOTAL_W-1] ? {1'b1, {(TOTAL_W-1){1'b0}}}
							: {1'b0, {(TOTAL_W-1){1'b1}}};
					end else begin
						total_q <= $signed(sum64);
					end
					state_q <= S_MNEG;
				end
				S_MNEG: begin
					cnt_q   <= ITER_W'(TOTAL_W - 1);
					state_q <= S_DIVM;
				end
				S_DIVM: begin
					if (cnt_q == '0) begin
						state_q <= S_MSAT;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_MSAT: begin
					mean_q  <= sat_drift(total_q[TOTAL_W-1], ALU_W'(dvd_q[TOTAL_W-1:0]));
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (load_out) begin
						prev_pos_q  <= pos_q;
						prev_time_q <= now_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					pos_q   <= new_pos;
					now_q   <= in_item.timestamp_ns;
					cyc_q   <= '0;
					valid_q <= 1'b0;
				end
			end
			S_PREP: begin
				dp_q <= pos_q - prev_pos_q;
				dt_q <= now_q - prev_time_q;
			end
			S_MAG: begin
				back_q   <= dp_q[POS_W-1];
				mplier_q <= dp_q[POS_W-1] ? (~dp_q + 1'b1) : dp_q;
				mcand_q  <= NUM_SCALE;
				acc_q    <= '0;
			end
			S_MULN, S_MULD: begin
				if (cnt_q == '0 && state_q == S_MULN) begin
					dvd_q    <= {alu_rsp.sum[PROD_W-1:0], {FRAC_BITS{1'b0}}};
					mcand_q  <= PROD_W'(dt_q);
					mplier_q <= POS_W'(sample_rate);
					acc_q    <= '0;
				end else begin
					mcand_q  <= {mcand_q[PROD_W-2:0], 1'b0};
					mplier_q <= {1'b0, mplier_q[POS_W-1:1]};
					acc_q    <= alu_rsp.sum;
					if (cnt_q == '0) begin
						den_q <= alu_rsp.sum[DEN_W-1:0];
						rem_q <= '0;
					end
				end
			end
			S_DIVD, S_DIVM: begin
				rem_q <= alu_rsp.cout ? alu_rsp.sum[DEN_W-1:0] : trial_in[DEN_W-1:0];
				dvd_q <= {dvd_q[NUM_W-2:0], alu_rsp.cout};
			end
			S_ADJ1: begin
				acc_q <= alu_rsp.sum;
				neg_q <= back_q || !alu_rsp.cout;
			end
			S_ADJ2: begin
				acc_q <= alu_rsp.sum;
			end
			S_SATC: begin
				cyc_q   <= sat_drift(neg_q, acc_q);
				valid_q <= 1'b1;
			end
			S_MNEG: begin
				dvd_q <= {tmag, {(NUM_W-TOTAL_W){1'b0}}};
				den_q <= DEN_W'(ev_q - 1'b1);
				rem_q <= '0;
			end
			S_DONE: begin
				if (load_out) begin
					result_q.position_frames <= pos_q;
					result_q.cycle_drift     <= cyc_q;
					result_q.average_drift   <= mean_q;
					result_q.event_count     <= ev_q;
					result_q.first_delay     <= first_delay_q;
					result_q.drift_valid     <= valid_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
